>>> sv/nlprc_pkg.sv
`default_nettype none

package nlprc_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int STORE_DEPTH = 64;
  localparam int IDX_W = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    RADIX_BIN = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_DEC = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  localparam radix_t OUT_RADIX_RST = RADIX_DEC;

endpackage

`default_nettype wire

>>> sv/nlprc_front.sv
`default_nettype none

module nlprc_front
  import nlprc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_character,
  input  wire logic                  in_final_char,
  input  wire logic                  q_full,
  output logic                       q_push,
  output logic [VALUE_BITS-1:0]      q_value,
  output logic                       q_err
);

  localparam logic [4:0] NO_DIGIT = 5'd16;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] ALPHA_OFS = 8'h37;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_PREFIX,
    PH_BODY
  } phase_t;

  phase_t                phase_r, phase_nxt;
  radix_t                radix_r, radix_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic                  err_r, err_nxt;

  logic                  accept;
  logic                  take;
  radix_t                eff;
  logic [7:0]            ch_f;
  logic [4:0]            dv;
  logic [4:0]            dsize;
  logic [VALUE_BITS-1:0] scaled;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    value_nxt = value_r;
    err_nxt   = err_r;
    take      = 1'b0;
    eff       = radix_r;

    case (phase_r)
      PH_PREFIX: begin
        phase_nxt = PH_BODY;
        if (in_character == CH_LO_X) begin
          radix_nxt = RADIX_HEX;
        end else if (in_character == CH_LO_B) begin
          radix_nxt = RADIX_BIN;
        end else begin
          radix_nxt = RADIX_OCT;
          eff       = RADIX_OCT;
          take      = 1'b1;
        end
      end
      PH_BODY: begin
        take = 1'b1;
      end
      default: begin
        if (in_character == CH_ZERO && !in_final_char) begin
          phase_nxt = PH_PREFIX;
        end else begin
          phase_nxt = PH_BODY;
          radix_nxt = RADIX_DEC;
          eff       = RADIX_DEC;
          take      = 1'b1;
        end
      end
    endcase

    // hex folds lower case
    if (eff == RADIX_HEX && in_character >= CH_LO_A && in_character <= CH_LO_Z) begin
      ch_f = in_character - CASE_OFS;
    end else begin
      ch_f = in_character;
    end

    if (ch_f >= CH_ZERO && ch_f <= CH_NINE) begin
      dv = 5'(ch_f - CH_ZERO);
    end else if (ch_f >= CH_UP_A && ch_f <= CH_UP_F) begin
      dv = 5'(ch_f - ALPHA_OFS);
    end else begin
      dv = NO_DIGIT;
    end

    case (eff)
      RADIX_BIN: begin
        dsize  = 5'd2;
        scaled = value_r << 1;
      end
      RADIX_OCT: begin
        dsize  = 5'd8;
        scaled = value_r << 3;
      end
      RADIX_HEX: begin
        dsize  = 5'd16;
        scaled = value_r << 4;
      end
      default: begin
        dsize  = 5'd10;
        scaled = (value_r << 3) + (value_r << 1);
      end
    endcase

    if (take) begin
      if (dv >= dsize) begin
        err_nxt = 1'b1;
      end else begin
        value_nxt = scaled + VALUE_BITS'(dv[3:0]);
      end
    end
  end

  assign q_push  = accept && in_final_char;
  assign q_value = value_nxt;
  assign q_err   = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      radix_r <= RADIX_DEC;
      value_r <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      if (in_final_char) begin
        phase_r <= PH_FIRST;
        radix_r <= RADIX_DEC;
        value_r <= '0;
        err_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        radix_r <= radix_nxt;
        value_r <= value_nxt;
        err_r   <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/nlprc_fifo.sv
`default_nettype none

module nlprc_fifo
  import nlprc_pkg::*;
#(
  parameter int WIDTH = VALUE_BITS_DEF + 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_r;
  logic             rd_r;
  logic [1:0]       cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/nlprc_back.sv
`default_nettype none

module nlprc_back
  import nlprc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire radix_t                out_radix,
  input  wire logic                  q_empty,
  input  wire logic [VALUE_BITS-1:0] q_value,
  input  wire logic                  q_err,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_digit_char,
  output logic                       out_bad_input,
  output logic                       out_run_end
);

  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(STORE_DEPTH);
  localparam logic [4:0] TEN = 5'd10;
  localparam logic [1:0] DS_LAST = 2'd3;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] ALPHA_OFS = 8'h37;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_RD,
    ST_SEND
  } state_t;

  function automatic logic [7:0] to_ascii(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + 8'(d);
    end else begin
      r = ALPHA_OFS + 8'(d);
    end
    return r;
  endfunction

  state_t                state_r;
  logic [VALUE_BITS-1:0] v_r;
  logic [VALUE_BITS-1:0] t_r;
  radix_t                radix_r;
  logic [1:0]            ds_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic                  out_valid_r;
  logic [7:0]            out_char_r;
  logic                  out_bad_r;
  logic                  out_end_r;

  logic [3:0]            store [STORE_DEPTH];
  logic [3:0]            rd_q;

  logic [VALUE_BITS-1:0] s1;
  logic [VALUE_BITS-1:0] s2;
  logic [VALUE_BITS-1:0] s3;
  logic [VALUE_BITS-1:0] s4;
  logic [VALUE_BITS-1:0] s5;
  logic [4:0]            q10_lo;
  logic [4:0]            r5;
  logic                  fix;
  logic [3:0]            dig_dec;
  logic [VALUE_BITS-1:0] q_fix;
  logic [3:0]            dig_p2;
  logic [VALUE_BITS-1:0] v_p2;
  logic                  is_dec;
  logic                  digit_done;
  logic [3:0]            dig;
  logic [VALUE_BITS-1:0] v_step;
  logic [CNT_W-1:0]      cnt_inc;
  logic                  conv_end;
  logic                  mem_we;
  logic                  out_free;
  logic                  out_load;

  // divide by ten as a shift-add reciprocal, with the partial sums registered in t_r
  always_comb begin
    s1 = (v_r >> 1) + (v_r >> 2);
    s2 = s1 + (s1 >> 4);
    s3 = t_r + (t_r >> 8);
    s4 = s3 + (s3 >> 16);
    s5 = (t_r + (t_r >> 32)) >> 3;

    // quotient estimate is low by at most one, remainder fits in five bits
    q10_lo  = {t_r[1:0], 3'b000} + {t_r[3:0], 1'b0};
    r5      = v_r[4:0] - q10_lo;
    fix     = (r5 >= TEN);
    dig_dec = fix ? 4'(r5 - TEN) : r5[3:0];
    q_fix   = t_r + VALUE_BITS'(fix);

    case (radix_r)
      RADIX_BIN: begin
        dig_p2 = {3'b000, v_r[0]};
        v_p2   = v_r >> 1;
      end
      RADIX_OCT: begin
        dig_p2 = {1'b0, v_r[2:0]};
        v_p2   = v_r >> 3;
      end
      RADIX_HEX: begin
        dig_p2 = v_r[3:0];
        v_p2   = v_r >> 4;
      end
      default: begin
        dig_p2 = 4'd0;
        v_p2   = v_r;
      end
    endcase

    is_dec     = (radix_r == RADIX_DEC);
    digit_done = !is_dec || (ds_r == DS_LAST);
    dig        = is_dec ? dig_dec : dig_p2;
    v_step     = is_dec ? q_fix : v_p2;
    cnt_inc    = cnt_r + CNT_W'(1);
    conv_end   = digit_done && ((v_step == '0) || (cnt_inc == CNT_CAP));
  end

  assign mem_we   = (state_r == ST_CONV) && digit_done;
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty && (!q_err || out_free);
  assign out_load = ((state_r == ST_IDLE) && q_pop && q_err) ||
                    ((state_r == ST_SEND) && out_free);

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_bad_input  = out_bad_r;
  assign out_run_end    = out_end_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[cnt_r[IDX_W-1:0]] <= dig;
    end
    rd_q <= store[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_err) begin
              out_char_r  <= 8'h00;
              out_bad_r   <= 1'b1;
              out_end_r   <= 1'b1;
            end else begin
              v_r     <= q_value;
              radix_r <= out_radix;
              ds_r    <= 2'd0;
              cnt_r   <= '0;
              state_r <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          if (is_dec) begin
            ds_r <= ds_r + 2'd1;
            case (ds_r)
              2'd0:    t_r <= s2;
              2'd1:    t_r <= s4;
              2'd2:    t_r <= s5;
              default: t_r <= t_r;
            endcase
          end
          if (digit_done) begin
            v_r   <= v_step;
            cnt_r <= cnt_inc;
          end
          if (conv_end) begin
            rd_idx_r <= cnt_r[IDX_W-1:0];
            state_r  <= ST_RD;
          end
        end
        ST_RD: begin
          state_r <= ST_SEND;
        end
        ST_SEND: begin
          if (out_free) begin
            out_char_r  <= to_ascii(rd_q);
            out_bad_r   <= 1'b0;
            out_end_r   <= (rd_idx_r == '0);
            if (rd_idx_r == '0) begin
              state_r <= ST_IDLE;
            end else begin
              rd_idx_r <= rd_idx_r - IDX_W'(1);
              state_r  <= ST_RD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/number_literal_parse_radix_convert.sv
// order: a literal's digits are stored during conversion and sent most significant first;
//   an error literal gives one error beat, through the literal queue and the output register
// throughput: one character per cycle, digits sent one beat at a time through the digit
//   store read port; input stalls while the two-entry literal queue is full
// reset: synchronous active-low rst_n clears the parser, the queue and the output valid;
//   out_radix returns to decimal
`default_nettype none

module number_literal_parse_radix_convert
  import nlprc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_out_radix,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_character,
  input  wire logic       in_final_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_digit_char,
  output logic            out_bad_input,
  output logic            out_run_end
);

  radix_t                out_radix_r;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_push;
  logic                  q_pop;
  logic [VALUE_BITS-1:0] f_value;
  logic                  f_err;
  logic [VALUE_BITS:0]   q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_radix_r <= OUT_RADIX_RST;
    end else if (cfg_valid && cfg_ready) begin
      out_radix_r <= radix_t'(cfg_out_radix);
    end
  end

  nlprc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .in_final_char(in_final_char),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_value      (f_value),
    .q_err        (f_err)
  );

  nlprc_fifo #(
    .WIDTH(VALUE_BITS + 1)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({f_err, f_value}),
    .pop      (q_pop),
    .pop_data (q_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  nlprc_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_radix     (out_radix_r),
    .q_empty       (q_empty),
    .q_value       (q_data[VALUE_BITS-1:0]),
    .q_err         (q_data[VALUE_BITS]),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_bad_input (out_bad_input),
    .out_run_end   (out_run_end)
  );

endmodule

`default_nettype wire

>>> bench/radix_digit_monitor.sv
`default_nettype none

module radix_digit_monitor
  import nlprc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [1:0] cfg_out_radix,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_character,
  input  wire logic       in_final_char,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_digit_char,
  input  wire logic       out_bad_input,
  input  wire logic       out_run_end,
  output int              fail_total,
  output int              pending_beats,
  output int              beats_seen,
  output int              bad_beats_seen
);

  localparam int NO_DIGIT = 16;

  typedef enum logic [1:0] {
    AT_START   = 2'd0,
    AFTER_ZERO = 2'd1,
    IN_BODY    = 2'd2
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] digit_char;
    logic       bad_input;
    logic       run_end;
  } digit_beat_t;

  radix_t                out_base;
  radix_t                in_base;
  parse_phase_t          ph;
  logic [VALUE_BITS-1:0] acc;
  logic                  bad_seen;
  digit_beat_t           expected_digits[$];
  int                    fails;
  int                    beats;
  int                    bad_beats;

  function automatic int radix_span(input radix_t base);
    case (base)
      RADIX_BIN: return 2;
      RADIX_OCT: return 8;
      RADIX_DEC: return 10;
      default:   return 16;
    endcase
  endfunction

  function automatic int digit_value(input logic [7:0] ch, input radix_t base);
    logic [7:0] c;
    int         d;
    c = ch;
    d = NO_DIGIT;
    if (base == RADIX_HEX && c >= "a" && c <= "z") c = c - 8'd32;
    if (c >= "0" && c <= "9") d = int'(c - "0");
    else if (c >= "A" && c <= "F") d = int'(c - "A") + 10;
    return (d < radix_span(base)) ? d : NO_DIGIT;
  endfunction

  function automatic logic [7:0] glyph(input logic [3:0] d);
    return (d < 10) ? 8'("0" + d) : 8'("A" + d - 10);
  endfunction

  function automatic void absorb_digit(input logic [7:0] ch);
    int d;
    d = digit_value(ch, in_base);
    if (d == NO_DIGIT) bad_seen = 1'b1;
    else acc = acc * 64'(radix_span(in_base)) + 64'(d);
  endfunction

  function automatic void clear_literal();
    ph = AT_START;
    in_base = RADIX_DEC;
    acc = '0;
    bad_seen = 1'b0;
  endfunction

  // one character in, the digit beats it causes queued
  function automatic void take_char(input logic [7:0] ch, input logic fin);
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] span;
    logic [3:0]            digits [STORE_DEPTH];
    int                    count;
    case (ph)
      AFTER_ZERO: begin
        ph = IN_BODY;
        if (ch == "x") begin
          in_base = RADIX_HEX;
        end else if (ch == "b") begin
          in_base = RADIX_BIN;
        end else begin
          in_base = RADIX_OCT;
          absorb_digit(ch);
        end
      end
      IN_BODY: absorb_digit(ch);
      default: begin
        if (ch == "0" && !fin) begin
          ph = AFTER_ZERO;
        end else begin
          ph = IN_BODY;
          in_base = RADIX_DEC;
          absorb_digit(ch);
        end
      end
    endcase
    if (!fin) return;
    if (bad_seen) begin
      expected_digits.push_back('{8'h00, 1'b1, 1'b1});
    end else begin
      v = acc;
      span = VALUE_BITS'(radix_span(out_base));
      count = 0;
      do begin
        digits[count] = 4'(v % span);
        v = v / span;
        count++;
      end while (v != 0 && count < STORE_DEPTH);
      for (int k = count - 1; k >= 0; k--)
        expected_digits.push_back('{glyph(digits[k]), 1'b0, k == 0});
    end
    clear_literal();
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    digit_beat_t want;
    if (!rst_n) begin
      out_base = OUT_RADIX_RST;
      clear_literal();
      expected_digits.delete();
      fails = 0;
      beats = 0;
      bad_beats = 0;
    end else begin
      if (cfg_valid && cfg_ready) out_base = radix_t'(cfg_out_radix);
      if (in_valid && !in_stall) take_char(in_character, in_final_char);
      if (out_valid && !out_stall) begin
        beats++;
        if (out_bad_input === 1'b1) bad_beats++;
        if (expected_digits.size() == 0) begin
          fails++;
          $display("%0t: unexpected beat, expected none actual char %h bad %b end %b",
                   $time, out_digit_char, out_bad_input, out_run_end);
        end else begin
          want = expected_digits.pop_front();
          check_field("digit_char", want.digit_char, out_digit_char);
          check_field("bad_input", 8'(want.bad_input), 8'(out_bad_input));
          check_field("run_end", 8'(want.run_end), 8'(out_run_end));
        end
      end
    end
    fail_total <= fails;
    pending_beats <= expected_digits.size();
    beats_seen <= beats;
    bad_beats_seen <= bad_beats;
  end

endmodule

`default_nettype wire

>>> bench/tb_number_literal_parse_radix_convert.sv
`default_nettype none

module tb_number_literal_parse_radix_convert;
  import nlprc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = VALUE_BITS_DEF + 16;
  localparam int PHASE_CHARS = 10;

  typedef byte unsigned char_q_t[$];

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_out_radix = RADIX_DEC;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_character = 8'h00;
  logic       in_final_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_digit_char;
  logic       out_bad_input;
  logic       out_run_end;

  int fail_total;
  int pending_beats;
  int beats_seen;
  int bad_beats_seen;

  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int stall_left = 0;
  int hold_draw;
  int literals_sent = 0;
  int chars_sent = 0;

  number_literal_parse_radix_convert dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_out_radix (cfg_out_radix),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_character  (in_character),
    .in_final_char (in_final_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_bad_input (out_bad_input),
    .out_run_end   (out_run_end)
  );

  radix_digit_monitor digit_watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_out_radix (cfg_out_radix),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_character  (in_character),
    .in_final_char (in_final_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_char(out_digit_char),
    .out_bad_input (out_bad_input),
    .out_run_end   (out_run_end),
    .fail_total    (fail_total),
    .pending_beats (pending_beats),
    .beats_seen    (beats_seen),
    .bad_beats_seen(bad_beats_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver hold-off after each beat, and now and then while idle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (!out_calm && ((out_valid && !out_stall) ||
                               (!out_valid && $urandom_range(0, 7) == 0))) begin
      hold_draw = $urandom_range(0, 10);
      stall_left <= hold_draw;
      out_stall <= (hold_draw != 0);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic char_q_t text(input string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic char_q_t random_literal();
    char_q_t q;
    string   hexset = "0123456789abcdefABCDEF";
    int      kind;
    int      len;
    kind = $urandom_range(0, 9);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 22) : $urandom_range(1, 5);
    case (kind)
      0, 1: begin
        q = text("0x");
        repeat (len) q.push_back(hexset[$urandom_range(0, 21)]);
      end
      2: begin
        q = text("0b");
        repeat (len) q.push_back($urandom_range(0, 1) ? "1" : "0");
      end
      3: begin
        q = text("0");
        repeat (len) q.push_back(8'("0" + $urandom_range(0, 7)));
      end
      4, 5: begin
        q.push_back(8'("1" + $urandom_range(0, 8)));
        repeat (len - 1) q.push_back(8'("0" + $urandom_range(0, 9)));
      end
      6: begin
        case ($urandom_range(0, 2))
          0: q = text("0");
          1: q = text("0x");
          default: q = text("0b");
        endcase
      end
      default: begin
        repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    if ($urandom_range(0, 5) == 0) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    return q;
  endfunction

  task automatic send_char(input byte unsigned c, input bit fin);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_character <= c;
    in_final_char <= fin;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_literal(input char_q_t lit);
    foreach (lit[i]) send_char(lit[i], i == lit.size() - 1);
    literals_sent++;
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_out_radix(input radix_t r);
    cfg_valid <= 1'b1;
    cfg_out_radix <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    char_q_t lit;
    radix_t  plan[$];
    int      budget;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: lone zero, bare prefixes, upper-case prefix letters, case folding,
    // lower-case outside hex, octal, binary, extreme character codes
    send_literal(text("0"));
    send_literal(text("0x"));
    send_literal(text("0b"));
    send_literal(text("0X"));
    send_literal(text("0B1"));
    send_literal(text("0xfA"));
    send_literal(text("7a"));
    send_literal(text("077"));
    send_literal(text("0b1"));
    lit.delete();
    lit.push_back(8'h00);
    send_literal(lit);
    lit.delete();
    lit.push_back(8'hFF);
    send_literal(lit);

    plan = '{RADIX_BIN, RADIX_HEX, RADIX_OCT, RADIX_DEC};
    plan.push_back(radix_t'($urandom_range(0, 3)));
    foreach (plan[p]) begin
      settle_idle();
      write_out_radix(plan[p]);
      if (p == 0) send_literal(text("0xFFFFFFFFFFFFFFFF"));
      if (p == 1) send_literal(text("18446744073709551617"));
      budget = chars_sent + PHASE_CHARS;
      while (chars_sent < budget) begin
        in_calm = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
        send_literal(random_literal());
        if ($urandom_range(0, 4) == 0) settle_idle();
      end
    end

    settle_idle();
    $display("sent %0d literals, %0d characters, output bases binary to hex",
             literals_sent, chars_sent);
    $display("checked %0d digit beats, %0d of them error beats", beats_seen, bad_beats_seen);
    if (fail_total == 0 && pending_beats == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> number_literal_parse_radix_convert.f
sv/nlprc_pkg.sv
sv/nlprc_front.sv
sv/nlprc_fifo.sv
sv/nlprc_back.sv
sv/number_literal_parse_radix_convert.sv
bench/radix_digit_monitor.sv
bench/tb_number_literal_parse_radix_convert.sv
